// ===== hw/rtl/mfb_pkg.sv =====
package mfb_pkg;

   localparam int MaxVertices = 64;
   localparam int EntryW      = 17;
   localparam int FlowW       = 22;
   localparam int CapW        = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_BFS_INIT,
      ST_BFS_POP,
      ST_BFS_SCAN,
      ST_BFS_WAIT,
      ST_NECK_RD,
      ST_NECK_WAIT,
      ST_UPD_FWD_RD,
      ST_UPD_FWD_WR,
      ST_UPD_REV_RD,
      ST_UPD_REV_WR,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;    // write zero at sweep address, advance sweep
      logic load_write;    // write load item into matrix
      logic bfs_init;      // clear visited, push source, neck to all ones
      logic bfs_pop;       // take head of queue as current vertex
      logic scan_read;     // read matrix row entry for scan vertex
      logic scan_eval;     // evaluate registered entry when one is pending
      logic walk_start;    // set walk vertex to sink, fetch its parent
      logic neck_read;     // read edge parent(v)->v
      logic neck_eval;     // fold into bottleneck, step walk
      logic fwd_read;      // read forward entry
      logic fwd_write;     // write forward entry minus neck
      logic rev_read;      // read reverse entry
      logic rev_write;     // write reverse entry plus neck, step walk
      logic flow_clear;    // clear flow total
      logic flow_add;      // add neck to total
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;    // sweep at last entry
      logic queue_empty;   // head reached tail
      logic scan_last;     // scan vertex is last in use
      logic sink_seen;     // sink visited
      logic walk_at_src;   // walk vertex is source
   } sts_type;

endpackage

// ===== hw/rtl/max_flow_bfs_augmenting_core.sv =====
// Operation: a load writes one matrix entry; a run repeats searches, each a row scan per
//   queued vertex (through the single matrix read port), then a bottleneck walk and
//   a residual update walk along the path edges.
// Throughput: one load per cycle when idle; one run at a time, busy until the strobe.
// Reset: synchronous; a clearing pass over every matrix entry zeroes the matrix,
//   busy high throughout. Results are strobed for one cycle; the receiver cannot stall.
module max_flow_bfs_augmenting_core #(
   parameter int MAX_VERTICES = mfb_pkg::MaxVertices
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [5:0]  req_from_vertex,
   input  logic [5:0]  req_to_vertex,
   input  logic [15:0] req_capacity,
   output logic        rsp_valid,
   output logic [21:0] rsp_max_flow,
   output logic        rsp_status,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int NW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] RegSource = 2'd0;
   localparam logic [1:0] RegSink   = 2'd1;
   localparam logic [1:0] RegCount  = 2'd2;

   logic [5:0] src_ff, snk_ff;
   logic [6:0] cnt_ff;
   logic [NW-1:0] n_use;
   logic load_ok, terms_ok, done, bad;
   mfb_pkg::cmd_type cmd;
   mfb_pkg::sts_type sts;
   logic [mfb_pkg::FlowW-1:0] flow;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= 6'd0;
         snk_ff <= 6'd63;
         cnt_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            RegSource: src_ff <= csr_data[5:0];
            RegSink:   snk_ff <= csr_data[5:0];
            RegCount:  cnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // saturate vertex count
   assign n_use = (32'(cnt_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(cnt_ff);
   assign load_ok = (NW'(req_from_vertex) < n_use) && (NW'(req_to_vertex) < n_use)
                    && (32'(req_from_vertex) < MAX_VERTICES)
                    && (32'(req_to_vertex) < MAX_VERTICES);
   assign terms_ok = (src_ff != snk_ff) && (NW'(src_ff) < n_use) && (NW'(snk_ff) < n_use)
                     && (32'(src_ff) < MAX_VERTICES) && (32'(snk_ff) < MAX_VERTICES);

   mfb_control u_ctrl (
      .clock, .reset, .start, .kind(req_kind), .load_ok, .terms_ok,
      .sts, .cmd, .busy, .done, .bad
   );

   mfb_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .load_from(VW'(req_from_vertex)), .load_to(VW'(req_to_vertex)),
      .load_cap(req_capacity),
      .src(VW'(src_ff)), .snk(VW'(snk_ff)), .n_use, .flow_total(flow)
   );

   assign rsp_valid    = done;
   assign rsp_status   = bad;
   assign rsp_max_flow = bad ? '0 : flow;

   bad_zero_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_max_flow == '0)) else $error("bad run flow");

endmodule

// ===== hw/rtl/mfb_datapath.sv =====
module mfb_datapath #(
   parameter int MAX_VERTICES = mfb_pkg::MaxVertices,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int AW = 2 * VW,
   localparam int NW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mfb_pkg::cmd_type          cmd,
   output mfb_pkg::sts_type          sts,
   input  logic [VW-1:0]             load_from,
   input  logic [VW-1:0]             load_to,
   input  logic [mfb_pkg::CapW-1:0]  load_cap,
   input  logic [VW-1:0]             src,
   input  logic [VW-1:0]             snk,
   input  logic [NW-1:0]             n_use,
   output logic [mfb_pkg::FlowW-1:0] flow_total
);

   logic [mfb_pkg::EntryW-1:0] mem [1 << AW];
   logic [mfb_pkg::EntryW-1:0] rd_ff;
   logic [VW-1:0]              parent [MAX_VERTICES];
   logic [VW-1:0]              queue [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]    visited_ff;
   logic [AW-1:0]              clr_ff;
   logic [NW-1:0]              head_ff, tail_ff;
   logic [VW-1:0]              cur_ff, scan_ff, scan_d_ff, walk_ff, par_ff;
   logic                       scan_vld_ff;
   logic [mfb_pkg::EntryW-1:0] neck_ff;
   logic [mfb_pkg::FlowW-1:0]  flow_ff;
   logic [mfb_pkg::EntryW-1:0] sub_val, add_val;
   logic                       push;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [mfb_pkg::EntryW-1:0] wr_data;
   logic                 rd_en;

   assign push = cmd.scan_eval && scan_vld_ff && !visited_ff[scan_d_ff] && (rd_ff != '0);
   assign sub_val = rd_ff - neck_ff;
   assign add_val = rd_ff + neck_ff;

   // select matrix port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = {cur_ff, scan_ff};
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.load_write) begin
         wr_en   = 1'b1;
         wr_addr = {load_from, load_to};
         wr_data = {1'b0, load_cap};
      end else if (cmd.fwd_write) begin
         wr_en   = 1'b1;
         wr_addr = {par_ff, walk_ff};
         wr_data = sub_val;
      end else if (cmd.rev_write) begin
         wr_en   = 1'b1;
         wr_addr = {walk_ff, par_ff};
         wr_data = add_val;
      end
      if (cmd.scan_read) begin
         rd_en = 1'b1;
      end else if (cmd.neck_read || cmd.fwd_read) begin
         rd_en   = 1'b1;
         rd_addr = {par_ff, walk_ff};
      end else if (cmd.rev_read) begin
         rd_en   = 1'b1;
         rd_addr = {walk_ff, par_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // queue and parent stores
   always_ff @(posedge clock) begin
      if (cmd.bfs_init) begin
         queue[0]    <= src;
         parent[src] <= src;
      end
      if (push) begin
         if (tail_ff < NW'(MAX_VERTICES)) begin
            queue[tail_ff[VW-1:0]] <= scan_d_ff;
         end
         parent[scan_d_ff] <= cur_ff;
      end
   end

   // search control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         visited_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         flow_ff     <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         scan_vld_ff <= cmd.scan_read;
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.bfs_init) begin
            visited_ff <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src;
            head_ff    <= '0;
            tail_ff    <= NW'(1);
         end
         if (cmd.bfs_pop) begin
            head_ff <= head_ff + 1'b1;
         end
         if (push) begin
            visited_ff[scan_d_ff] <= 1'b1;
            if (tail_ff < NW'(MAX_VERTICES)) begin
               tail_ff <= tail_ff + 1'b1;
            end
         end
         if (cmd.flow_clear) begin
            flow_ff <= '0;
         end else if (cmd.flow_add) begin
            flow_ff <= flow_ff + mfb_pkg::FlowW'(neck_ff);
         end
      end
   end

   // walk and scan registers
   always_ff @(posedge clock) begin
      if (cmd.bfs_pop) begin
         cur_ff  <= queue[head_ff[VW-1:0]];
         scan_ff <= '0;
      end
      if (cmd.scan_read) begin
         scan_d_ff <= scan_ff;
         scan_ff   <= scan_ff + 1'b1;
      end
      if (cmd.bfs_init) begin
         neck_ff <= '1;
      end
      if (cmd.walk_start) begin
         walk_ff <= snk;
         par_ff  <= parent[snk];
      end
      if (cmd.neck_eval) begin
         if (rd_ff < neck_ff) begin
            neck_ff <= rd_ff;
         end
         walk_ff <= par_ff;
         par_ff  <= parent[par_ff];
      end
      if (cmd.rev_write) begin
         walk_ff <= par_ff;
         par_ff  <= parent[par_ff];
      end
   end

   always_comb begin
      sts.clear_last  = (clr_ff == '1);
      sts.queue_empty = (head_ff == tail_ff);
      sts.scan_last   = (NW'(scan_ff) + 1'b1 >= n_use) || (scan_ff == '1);
      sts.sink_seen   = visited_ff[snk];
      sts.walk_at_src = (walk_ff == src);
   end

   assign flow_total = flow_ff;

   tail_le_max: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= NW'(MAX_VERTICES)) else $error("queue tail overrun");
   head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");
   no_dual_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_write && cmd.fwd_write)) else $error("write port conflict");

endmodule

// ===== hw/rtl/mfb_control.sv =====
module mfb_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    kind,
   input  logic                    load_ok,
   input  logic                    terms_ok,
   input  mfb_pkg::sts_type        sts,
   output mfb_pkg::cmd_type        cmd,
   output logic                    busy,
   output logic                    done,
   output logic                    bad
);

   mfb_pkg::state_type state_ff, state_in;
   logic bad_ff, bad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfb_pkg::ST_CLEAR;
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         bad_ff   <= bad_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      bad_in   = bad_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      unique case (state_ff)
         mfb_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (!kind) begin
                  cmd.load_write = load_ok;
               end else begin
                  cmd.flow_clear = 1'b1;
                  bad_in   = !terms_ok;
                  state_in = terms_ok ? mfb_pkg::ST_BFS_INIT : mfb_pkg::ST_DONE;
               end
            end
         end
         mfb_pkg::ST_BFS_INIT: begin
            cmd.bfs_init = 1'b1;
            state_in = mfb_pkg::ST_BFS_POP;
         end
         mfb_pkg::ST_BFS_POP: begin
            if (sts.queue_empty) begin
               if (sts.sink_seen) begin
                  cmd.walk_start = 1'b1;
                  state_in = mfb_pkg::ST_NECK_RD;
               end else begin
                  state_in = mfb_pkg::ST_DONE;
               end
            end else begin
               cmd.bfs_pop = 1'b1;
               state_in = mfb_pkg::ST_BFS_SCAN;
            end
         end
         mfb_pkg::ST_BFS_SCAN: begin
            cmd.scan_read = 1'b1;
            cmd.scan_eval = 1'b1;
            if (sts.scan_last) state_in = mfb_pkg::ST_BFS_WAIT;
         end
         mfb_pkg::ST_BFS_WAIT: begin
            cmd.scan_eval = 1'b1;
            state_in = mfb_pkg::ST_BFS_POP;
         end
         mfb_pkg::ST_NECK_RD: begin
            if (sts.walk_at_src) begin
               cmd.walk_start = 1'b1;
               state_in = mfb_pkg::ST_UPD_FWD_RD;
            end else begin
               cmd.neck_read = 1'b1;
               state_in = mfb_pkg::ST_NECK_WAIT;
            end
         end
         mfb_pkg::ST_NECK_WAIT: begin
            cmd.neck_eval = 1'b1;
            state_in = mfb_pkg::ST_NECK_RD;
         end
         mfb_pkg::ST_UPD_FWD_RD: begin
            if (sts.walk_at_src) begin
               cmd.flow_add = 1'b1;
               state_in = mfb_pkg::ST_BFS_INIT;
            end else begin
               cmd.fwd_read = 1'b1;
               state_in = mfb_pkg::ST_UPD_FWD_WR;
            end
         end
         mfb_pkg::ST_UPD_FWD_WR: begin
            cmd.fwd_write = 1'b1;
            state_in = mfb_pkg::ST_UPD_REV_RD;
         end
         mfb_pkg::ST_UPD_REV_RD: begin
            cmd.rev_read = 1'b1;
            state_in = mfb_pkg::ST_UPD_REV_WR;
         end
         mfb_pkg::ST_UPD_REV_WR: begin
            cmd.rev_write = 1'b1;
            state_in = mfb_pkg::ST_UPD_FWD_RD;
         end
         mfb_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = mfb_pkg::ST_IDLE;
         end
         default: state_in = mfb_pkg::ST_IDLE;
      endcase
   end

   assign bad = bad_ff;

   done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("result strobe held");
   idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy) else $error("not idle after result");

endmodule
